FILE: rtl/sgsrw_pkg.sv
// Shared types, constants and the gain threshold table of the exposure register writer.
// No dependencies; used by sgsrw_front, sgsrw_queue, sgsrw_back and the top level.
package sgsrw_pkg;

    // Field widths of the command and result words.
    localparam int GAIN_IN_W  = 18;
    localparam int LINES_W    = 24;
    localparam int ADDR_W     = 16;
    localparam int DATA_W     = 8;

    // Clamped gain fits in 17 bits (125000 < 2^17).
    localparam int GAIN_W     = 17;

    // Step code search: 420 thresholds padded to a power of two.
    localparam int CODE_MAX     = 420;
    localparam int TAB_DEPTH    = 512;
    localparam int CODE_W       = $clog2(TAB_DEPTH);
    localparam int SEARCH_STEPS = CODE_W;

    localparam logic [GAIN_IN_W-1:0] GAIN_MIN = GAIN_IN_W'(1000);
    localparam logic [GAIN_IN_W-1:0] GAIN_MAX = GAIN_IN_W'(125000);

    // Reset value of the frame length register.
    localparam logic [LINES_W-1:0] FRAME_LINES_RST = LINES_W'(1125);

    // Default depth of the queue between front and back.
    localparam int QUEUE_DEPTH_DEF = 4;

    // Command kinds.
    localparam logic KIND_GAIN    = 1'b0;
    localparam logic KIND_SHUTTER = 1'b1;

    // Sensor register addresses of the gain and exposure settings.
    localparam logic [ADDR_W-1:0] ADDR_GAIN_LO = 16'h0214;
    localparam logic [ADDR_W-1:0] ADDR_GAIN_HI = 16'h0215;
    localparam logic [ADDR_W-1:0] ADDR_OFF_HI  = 16'h0222;
    localparam logic [ADDR_W-1:0] ADDR_OFF_MID = 16'h0221;
    localparam logic [ADDR_W-1:0] ADDR_OFF_LO  = 16'h0220;
    localparam logic [ADDR_W-1:0] ADDR_FRM_HI  = 16'h021A;
    localparam logic [ADDR_W-1:0] ADDR_FRM_MID = 16'h0219;
    localparam logic [ADDR_W-1:0] ADDR_FRM_LO  = 16'h0218;

    // A classified command as it travels from the front to the back.
    typedef struct packed {
        logic               kind;
        logic [CODE_W-1:0]  code;
        logic [LINES_W-1:0] offset;
        logic [LINES_W-1:0] frame;
    } t_cmd;

    typedef logic [GAIN_W-1:0] t_thr_tab [TAB_DEPTH];

    // Entry k holds the smallest integer gain whose step code is at least k.
    // Entry 0 is zero so that it always matches; entries past the last
    // threshold hold the largest value so that a clamped gain never reaches them.
    function automatic t_thr_tab f_gain_thr();
        t_thr_tab    tab;
        real         t;
        int unsigned v;
        for (int k = 0; k < TAB_DEPTH; k++) begin
            if (k == 0) begin
                tab[k] = '0;
            end else if (k <= CODE_MAX) begin
                t = 1000.0 * (10.0 ** (real'(2 * k - 1) / 400.0));
                v = $rtoi(t);
                if (real'(v) < t) begin
                    v = v + 1;
                end
                tab[k] = GAIN_W'(v);
            end else begin
                tab[k] = '1;
            end
        end
        return tab;
    endfunction

    localparam t_thr_tab GAIN_THR = f_gain_thr();

endpackage

FILE: rtl/sensor_gain_shutter_reg_writer.sv
// Top level of the exposure command to sensor register writer: frame length register,
// front end, command queue and write sequencer. Uses sgsrw_pkg and the sgsrw_* modules.
//
// Each command produces its register writes as result words, one word per clock at
// most: a gain command gives two words and a shutter command six, so the write
// sequencer's word rate sets the sustained command rate. The front end accepts
// a command every cycle while the queue has room; the gain step code comes from
// a nine-step binary search over a constant threshold table, so a command passes
// the classify stage and the search stages before it reaches the queue, and its
// first word is registered in the sequencer's output register. The frame length
// register resets to 1125 lines and should only be written while no command is in flight.
module sensor_gain_shutter_reg_writer #(
    parameter int QUEUE_DEPTH = sgsrw_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [sgsrw_pkg::LINES_W-1:0]   i_cfg_wdata,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic                            i_kind,
    input  logic [sgsrw_pkg::GAIN_IN_W-1:0] i_gain_milli,
    input  logic [sgsrw_pkg::LINES_W-1:0]   i_shutter_lines,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [sgsrw_pkg::ADDR_W-1:0]    o_reg_addr,
    output logic [sgsrw_pkg::DATA_W-1:0]    o_reg_data,
    output logic                            o_last
);

    logic [sgsrw_pkg::LINES_W-1:0] r_frame_lines;
    logic                          w_f2q_valid;
    logic                          w_f2q_ready;
    sgsrw_pkg::t_cmd               w_f2q_cmd;
    logic                          w_q2b_valid;
    logic                          w_q2b_ready;
    sgsrw_pkg::t_cmd               w_q2b_cmd;

    // Frame length configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_lines <= sgsrw_pkg::FRAME_LINES_RST;
        end else if (i_cfg_we) begin
            r_frame_lines <= i_cfg_wdata;
        end
    end

    sgsrw_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_kind          (i_kind),
        .i_gain_milli    (i_gain_milli),
        .i_shutter_lines (i_shutter_lines),
        .i_frame_lines   (r_frame_lines),
        .o_cmd_valid     (w_f2q_valid),
        .i_cmd_ready     (w_f2q_ready),
        .o_cmd           (w_f2q_cmd)
    );

    sgsrw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_f2q_valid),
        .o_ready (w_f2q_ready),
        .i_cmd   (w_f2q_cmd),
        .o_valid (w_q2b_valid),
        .i_ready (w_q2b_ready),
        .o_cmd   (w_q2b_cmd)
    );

    sgsrw_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_q2b_valid),
        .o_ready    (w_q2b_ready),
        .i_cmd      (w_q2b_cmd),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_reg_addr (o_reg_addr),
        .o_reg_data (o_reg_data),
        .o_last     (o_last)
    );

endmodule

FILE: rtl/sgsrw_front.sv
// Front end: accepts commands, clamps the gain, works out shutter offset and frame
// length, and finds the gain step code by a pipelined binary search. Uses sgsrw_pkg.
module sgsrw_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic                           i_kind,
    input  logic [sgsrw_pkg::GAIN_IN_W-1:0] i_gain_milli,
    input  logic [sgsrw_pkg::LINES_W-1:0]   i_shutter_lines,
    input  logic [sgsrw_pkg::LINES_W-1:0]   i_frame_lines,
    output logic                           o_cmd_valid,
    input  logic                           i_cmd_ready,
    output sgsrw_pkg::t_cmd                o_cmd
);

    localparam int NSTG = sgsrw_pkg::SEARCH_STEPS + 1;
    localparam int CW   = sgsrw_pkg::CODE_W;

    logic [NSTG-1:0]                  r_vld;
    sgsrw_pkg::t_cmd                  r_cmd  [NSTG];
    sgsrw_pkg::t_cmd                  n_cmd  [NSTG];
    logic [sgsrw_pkg::GAIN_W-1:0]     r_gain [sgsrw_pkg::SEARCH_STEPS];
    logic [sgsrw_pkg::GAIN_W-1:0]     n_gain [sgsrw_pkg::SEARCH_STEPS];
    logic                             w_adv;
    logic                             w_short;

    // The whole pipeline moves together whenever its last stage can hand on.
    assign w_adv   = !r_vld[NSTG-1] || i_cmd_ready;
    assign o_ready = w_adv;
    assign w_short = i_shutter_lines < i_frame_lines;

    // Stage 0 classifies; each later stage settles one bit of the step code.
    always_comb begin
        logic [CW-1:0] v_bit;
        logic [CW-1:0] v_keep;
        logic [CW-1:0] v_idx;
        v_bit  = '0;
        v_keep = '0;
        v_idx  = '0;

        if (i_gain_milli < sgsrw_pkg::GAIN_MIN) begin
            n_gain[0] = sgsrw_pkg::GAIN_W'(sgsrw_pkg::GAIN_MIN);
        end else if (i_gain_milli > sgsrw_pkg::GAIN_MAX) begin
            n_gain[0] = sgsrw_pkg::GAIN_W'(sgsrw_pkg::GAIN_MAX);
        end else begin
            n_gain[0] = i_gain_milli[sgsrw_pkg::GAIN_W-1:0];
        end
        for (int s = 1; s < sgsrw_pkg::SEARCH_STEPS; s++) begin
            n_gain[s] = r_gain[s-1];
        end

        n_cmd[0].kind   = i_kind;
        n_cmd[0].code   = '0;
        n_cmd[0].offset = w_short ? (i_frame_lines - i_shutter_lines) : '0;
        n_cmd[0].frame  = w_short ? i_frame_lines : i_shutter_lines;

        for (int s = 1; s < NSTG; s++) begin
            v_bit  = CW'(1) << (sgsrw_pkg::SEARCH_STEPS - s);
            v_keep = ~((v_bit << 1) - CW'(1));
            v_idx  = (r_cmd[s-1].code & v_keep) | v_bit;
            n_cmd[s] = r_cmd[s-1];
            if (sgsrw_pkg::GAIN_THR[v_idx] <= r_gain[s-1]) begin
                n_cmd[s].code = r_cmd[s-1].code | v_bit;
            end
        end
    end

    // Stage valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[NSTG-2:0], i_valid};
        end
    end

    // Stage payloads.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int s = 0; s < NSTG; s++) begin
                r_cmd[s] <= n_cmd[s];
            end
            for (int s = 0; s < sgsrw_pkg::SEARCH_STEPS; s++) begin
                r_gain[s] <= n_gain[s];
            end
        end
    end

    assign o_cmd_valid = r_vld[NSTG-1];
    assign o_cmd       = r_cmd[NSTG-1];

endmodule

FILE: rtl/sgsrw_queue.sv
// Short command queue between the front end and the write sequencer.
// Uses sgsrw_pkg for the command type.
module sgsrw_queue #(
    parameter int DEPTH = sgsrw_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  sgsrw_pkg::t_cmd i_cmd,
    output logic            o_valid,
    input  logic            i_ready,
    output sgsrw_pkg::t_cmd o_cmd
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    sgsrw_pkg::t_cmd r_mem [DEPTH];
    logic [AW-1:0]   r_wr_ptr;
    logic [AW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic            w_push;
    logic            w_pop;

    assign o_ready = r_count != CW'(DEPTH);
    assign o_valid = r_count != '0;
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;
    assign o_cmd   = r_mem[r_rd_ptr];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + CW'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

FILE: rtl/sgsrw_back.sv
// Write sequencer: turns each queued command into its run of register writes,
// one word per cycle while the output is taken, through an output register. Uses sgsrw_pkg.
module sgsrw_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  sgsrw_pkg::t_cmd              i_cmd,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [sgsrw_pkg::ADDR_W-1:0] o_reg_addr,
    output logic [sgsrw_pkg::DATA_W-1:0] o_reg_data,
    output logic                         o_last
);

    // Word positions within a command.
    localparam logic [2:0] B_GAIN_LO  = 3'd0;
    localparam logic [2:0] B_GAIN_HI  = 3'd1;
    localparam logic [2:0] B_OFF_HI   = 3'd0;
    localparam logic [2:0] B_OFF_MID  = 3'd1;
    localparam logic [2:0] B_OFF_LO   = 3'd2;
    localparam logic [2:0] B_FRM_HI   = 3'd3;
    localparam logic [2:0] B_FRM_MID  = 3'd4;
    localparam logic [2:0] B_FRM_LO   = 3'd5;

    typedef struct packed {
        logic [sgsrw_pkg::ADDR_W-1:0] addr;
        logic [sgsrw_pkg::DATA_W-1:0] data;
        logic                         last;
    } t_word;

    logic            r_busy;
    logic [2:0]      r_beat;
    sgsrw_pkg::t_cmd r_cmd;
    logic            r_out_valid;
    t_word           r_word;
    logic            w_load;
    sgsrw_pkg::t_cmd w_sel_cmd;
    logic [2:0]      w_sel_beat;
    t_word           w_word;

    // The output register can take a new word when empty or being drained.
    assign w_load  = !r_out_valid || i_ready;
    assign o_ready = w_load && !r_busy;

    // Pick the word to emit: the next one of the current command, or the
    // first one of a fresh command from the queue.
    always_comb begin
        w_sel_cmd  = r_busy ? r_cmd : i_cmd;
        w_sel_beat = r_busy ? r_beat : 3'd0;
        w_word     = '0;
        if (w_sel_cmd.kind == sgsrw_pkg::KIND_GAIN) begin
            case (w_sel_beat)
                B_GAIN_LO: begin
                    w_word.addr = sgsrw_pkg::ADDR_GAIN_LO;
                    w_word.data = w_sel_cmd.code[7:0];
                    w_word.last = 1'b0;
                end
                default: begin
                    w_word.addr = sgsrw_pkg::ADDR_GAIN_HI;
                    w_word.data = sgsrw_pkg::DATA_W'(w_sel_cmd.code[sgsrw_pkg::CODE_W-1:8]);
                    w_word.last = 1'b1;
                end
            endcase
        end else begin
            case (w_sel_beat)
                B_OFF_HI: begin
                    w_word.addr = sgsrw_pkg::ADDR_OFF_HI;
                    w_word.data = w_sel_cmd.offset[23:16];
                end
                B_OFF_MID: begin
                    w_word.addr = sgsrw_pkg::ADDR_OFF_MID;
                    w_word.data = w_sel_cmd.offset[15:8];
                end
                B_OFF_LO: begin
                    w_word.addr = sgsrw_pkg::ADDR_OFF_LO;
                    w_word.data = w_sel_cmd.offset[7:0];
                end
                B_FRM_HI: begin
                    w_word.addr = sgsrw_pkg::ADDR_FRM_HI;
                    w_word.data = w_sel_cmd.frame[23:16];
                end
                B_FRM_MID: begin
                    w_word.addr = sgsrw_pkg::ADDR_FRM_MID;
                    w_word.data = w_sel_cmd.frame[15:8];
                end
                default: begin
                    w_word.addr = sgsrw_pkg::ADDR_FRM_LO;
                    w_word.data = w_sel_cmd.frame[7:0];
                    w_word.last = 1'b1;
                end
            endcase
        end
    end

    // Sequencer state and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_beat      <= 3'd0;
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            if (r_busy || i_valid) begin
                r_out_valid <= 1'b1;
                r_word      <= w_word;
                r_cmd       <= w_sel_cmd;
                r_beat      <= w_sel_beat + 3'd1;
                r_busy      <= !w_word.last;
            end else begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid    = r_out_valid;
    assign o_reg_addr = r_word.addr;
    assign o_reg_data = r_word.data;
    assign o_last     = r_word.last;

    // A command still in progress always has a word on show.
    a_busy_has_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_out_valid)
        else $error("sequencer busy without an output word");

    // Once the closing word of a command is shown, nothing of it remains.
    a_last_ends_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_word.last) |-> !r_busy)
        else $error("command still busy after its last word");

    // A gain command only ever has its high byte left to send.
    a_gain_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_cmd.kind == sgsrw_pkg::KIND_GAIN) |-> (r_beat == B_GAIN_HI))
        else $error("gain command beyond its second word");

    // A shutter command left pending sits between its second and last word.
    a_shutter_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_cmd.kind == sgsrw_pkg::KIND_SHUTTER)
        |-> (r_beat == B_OFF_MID || r_beat == B_OFF_LO || r_beat == B_FRM_HI
             || r_beat == B_FRM_MID || r_beat == B_FRM_LO))
        else $error("shutter command word position out of range");

endmodule

FILE: tb/sv/sgsrw_write_checker.sv
// Checker for the exposure register writer: watches both channels and the frame length port.
// It predicts each command's register writes and compares them; needs only sgsrw_pkg.
module sgsrw_write_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [sgsrw_pkg::LINES_W-1:0]   i_cfg_wdata,
    input  logic                            i_cmd_valid,
    input  logic                            i_cmd_ready,
    input  logic                            i_kind,
    input  logic [sgsrw_pkg::GAIN_IN_W-1:0] i_gain_milli,
    input  logic [sgsrw_pkg::LINES_W-1:0]   i_shutter_lines,
    input  logic                            i_wr_valid,
    input  logic                            i_wr_ready,
    input  logic [sgsrw_pkg::ADDR_W-1:0]    i_reg_addr,
    input  logic [sgsrw_pkg::DATA_W-1:0]    i_reg_data,
    input  logic                            i_last,
    output int                              o_err_count,
    output int                              o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [sgsrw_pkg::ADDR_W-1:0] addr;
        logic [sgsrw_pkg::DATA_W-1:0] data;
        logic                         last;
    } t_reg_write;

    t_reg_write                    writes_due[$];
    logic [sgsrw_pkg::LINES_W-1:0] frame_lines;
    int                            err_total;

    // One line per mismatch, and the count goes up.
    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("[%0t] ERROR %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        err_total++;
    endtask

    // Step code in tenths of a decibel, round(200*log10(g/1000)) on the clamped gain.
    // Integer gains sit far enough from the half steps for double precision to be exact.
    function automatic int gain_step_code(input logic [sgsrw_pkg::GAIN_IN_W-1:0] gain);
        int unsigned g;
        real         steps;
        int          code;
        g = gain;
        if (g < 1000) begin
            g = 1000;
        end
        if (g > 125000) begin
            g = 125000;
        end
        steps = 200.0 * $log10(real'(g) / 1000.0) + 0.5;
        code  = $rtoi(steps);
        if (code > sgsrw_pkg::CODE_MAX) begin
            code = sgsrw_pkg::CODE_MAX;
        end
        return code;
    endfunction

    task automatic add_write(input logic [sgsrw_pkg::ADDR_W-1:0] addr,
                             input logic [sgsrw_pkg::DATA_W-1:0] data,
                             input logic last);
        t_reg_write w;
        w.addr = addr;
        w.data = data;
        w.last = last;
        writes_due.push_back(w);
    endtask

    // Expected run of register writes for one exposure command.
    task automatic push_exposure_writes(input logic kind,
                                        input logic [sgsrw_pkg::GAIN_IN_W-1:0] gain,
                                        input logic [sgsrw_pkg::LINES_W-1:0] lines);
        logic [15:0]                   code;
        logic [sgsrw_pkg::LINES_W-1:0] offset;
        logic [sgsrw_pkg::LINES_W-1:0] frame;
        if (kind == sgsrw_pkg::KIND_GAIN) begin
            code = 16'(gain_step_code(gain));
            add_write(sgsrw_pkg::ADDR_GAIN_LO, code[7:0], 1'b0);
            add_write(sgsrw_pkg::ADDR_GAIN_HI, code[15:8], 1'b1);
        end else begin
            offset = (lines < frame_lines) ? frame_lines - lines : '0;
            frame  = (lines < frame_lines) ? frame_lines : lines;
            add_write(sgsrw_pkg::ADDR_OFF_HI, offset[23:16], 1'b0);
            add_write(sgsrw_pkg::ADDR_OFF_MID, offset[15:8], 1'b0);
            add_write(sgsrw_pkg::ADDR_OFF_LO, offset[7:0], 1'b0);
            add_write(sgsrw_pkg::ADDR_FRM_HI, frame[23:16], 1'b0);
            add_write(sgsrw_pkg::ADDR_FRM_MID, frame[15:8], 1'b0);
            add_write(sgsrw_pkg::ADDR_FRM_LO, frame[7:0], 1'b1);
        end
    endtask

    // Sample at each rising edge: configuration, accepted commands, then accepted words.
    always @(posedge i_clk) begin : watch
        t_reg_write want;
        if (!i_rst_n) begin
            frame_lines = sgsrw_pkg::FRAME_LINES_RST;
            writes_due.delete();
        end else begin
            if (i_cfg_we) begin
                frame_lines = i_cfg_wdata;
            end
            if (i_cmd_valid && i_cmd_ready) begin
                push_exposure_writes(i_kind, i_gain_milli, i_shutter_lines);
            end
            if (i_wr_valid && i_wr_ready) begin
                if (writes_due.size() == 0) begin
                    report_mismatch("unexpected word, addr", i_reg_addr, 0);
                end else begin
                    want = writes_due.pop_front();
                    if (i_reg_addr !== want.addr) begin
                        report_mismatch("reg_addr", i_reg_addr, want.addr);
                    end
                    if (i_reg_data !== want.data) begin
                        report_mismatch("reg_data", i_reg_data, want.data);
                    end
                    if (i_last !== want.last) begin
                        report_mismatch("last", i_last, want.last);
                    end
                end
            end
        end
        o_pending   <= writes_due.size();
        o_err_count <= err_total;
    end

endmodule

FILE: tb/sv/sensor_gain_shutter_reg_writer_tb.sv
// Testbench top for the exposure register writer: clock, reset, commands and frame lengths.
// Instantiates the block and sgsrw_write_checker, which does the prediction and comparison.
module sensor_gain_shutter_reg_writer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DRAIN_CYCLES   = 16;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASES         = 8;
    localparam int PHASE_ITEMS    = 49;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            i_cfg_we;
    logic [sgsrw_pkg::LINES_W-1:0]   i_cfg_wdata;
    logic                            i_valid;
    logic                            o_ready;
    logic                            i_kind;
    logic [sgsrw_pkg::GAIN_IN_W-1:0] i_gain_milli;
    logic [sgsrw_pkg::LINES_W-1:0]   i_shutter_lines;
    logic                            o_valid;
    logic                            i_ready;
    logic [sgsrw_pkg::ADDR_W-1:0]    o_reg_addr;
    logic [sgsrw_pkg::DATA_W-1:0]    o_reg_data;
    logic                            o_last;

    int                              err_count;
    int                              writes_pending;
    logic                            sender_eager;
    logic                            sink_eager;
    logic [sgsrw_pkg::LINES_W-1:0]   frame_cfg;

    sensor_gain_shutter_reg_writer u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_kind          (i_kind),
        .i_gain_milli    (i_gain_milli),
        .i_shutter_lines (i_shutter_lines),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_reg_addr      (o_reg_addr),
        .o_reg_data      (o_reg_data),
        .o_last          (o_last)
    );

    sgsrw_write_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_cmd_valid     (i_valid),
        .i_cmd_ready     (o_ready),
        .i_kind          (i_kind),
        .i_gain_milli    (i_gain_milli),
        .i_shutter_lines (i_shutter_lines),
        .i_wr_valid      (o_valid),
        .i_wr_ready      (i_ready),
        .i_reg_addr      (o_reg_addr),
        .i_reg_data      (o_reg_data),
        .i_last          (o_last),
        .o_err_count     (err_count),
        .o_pending       (writes_pending)
    );

    always #5 i_clk = ~i_clk;

    // Idle cycles before the next word; none at all while a side is marked eager.
    function automatic int idle_gap(input logic eager);
        if (eager || $urandom_range(0, 3) == 0) begin
            return 0;
        end
        return $urandom_range(0, 18);
    endfunction

    // Result side: stall a random number of cycles, then take one word.
    initial begin : sink
        int stall;
        i_ready = 1'b0;
        @(posedge i_clk);
        forever begin
            stall = idle_gap(sink_eager);
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    // Ends the run when nothing has moved for too long.
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || i_cfg_we || (i_valid && o_ready) || (o_valid && i_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("Some tests failed");
        $finish;
    end

    // Send one command word; returns after the edge at which it is accepted.
    task automatic send_command(input logic kind, input logic [sgsrw_pkg::GAIN_IN_W-1:0] gain,
                                input logic [sgsrw_pkg::LINES_W-1:0] lines);
        int gap;
        gap = idle_gap(sender_eager);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_kind          <= kind;
        i_gain_milli    <= gain;
        i_shutter_lines <= lines;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // Hold off until the checker has no writes outstanding.
    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (writes_pending != 0);
    endtask

    // Frame length is only changed with the block idle.
    task automatic write_frame_lines(input logic [sgsrw_pkg::LINES_W-1:0] value);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        frame_cfg    = value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Gains spread over the whole field, around the clamps and on rounding thresholds.
    function automatic logic [sgsrw_pkg::GAIN_IN_W-1:0] pick_gain();
        int  k;
        real thr;
        case ($urandom_range(0, 7))
            0, 1: begin
                return sgsrw_pkg::GAIN_IN_W'($urandom_range(0, 262143));
            end
            2: begin
                return sgsrw_pkg::GAIN_IN_W'($urandom_range(0, 1100));
            end
            3: begin
                return sgsrw_pkg::GAIN_IN_W'($urandom_range(124900, 125100));
            end
            4, 5: begin
                k   = $urandom_range(1, 419);
                thr = 1000.0 * (10.0 ** (real'(2 * k - 1) / 400.0));
                return sgsrw_pkg::GAIN_IN_W'($rtoi(thr) + $urandom_range(0, 1));
            end
            default: begin
                return sgsrw_pkg::GAIN_IN_W'($urandom_range(1000, 125000));
            end
        endcase
    endfunction

    // Exposures around the current frame length as well as across the full field.
    function automatic logic [sgsrw_pkg::LINES_W-1:0] pick_exposure();
        case ($urandom_range(0, 5))
            0: begin
                return sgsrw_pkg::LINES_W'($urandom());
            end
            1: begin
                return frame_cfg + sgsrw_pkg::LINES_W'($urandom_range(0, 6))
                       - sgsrw_pkg::LINES_W'(3);
            end
            2: begin
                return sgsrw_pkg::LINES_W'($urandom_range(0, 4095));
            end
            3: begin
                return $urandom_range(0, 1) ? '1 : '0;
            end
            default: begin
                return sgsrw_pkg::LINES_W'($urandom_range(0, 2 * int'(frame_cfg) + 2));
            end
        endcase
    endfunction

    task automatic send_random_command();
        logic kind;
        kind = $urandom_range(0, 1) ? sgsrw_pkg::KIND_SHUTTER : sgsrw_pkg::KIND_GAIN;
        send_command(kind, pick_gain(), pick_exposure());
    endtask

    // Clamp edges, exact decades, the top code and exposures around the reset frame length.
    task automatic run_directed();
        send_command(sgsrw_pkg::KIND_GAIN, 18'd0, '1);
        send_command(sgsrw_pkg::KIND_GAIN, 18'd999, '0);
        send_command(sgsrw_pkg::KIND_GAIN, 18'd1000, '1);
        send_command(sgsrw_pkg::KIND_GAIN, 18'd1001, 24'h5A5A5A);
        send_command(sgsrw_pkg::KIND_GAIN, 18'd1122, '0);
        send_command(sgsrw_pkg::KIND_GAIN, 18'd1123, '0);
        send_command(sgsrw_pkg::KIND_GAIN, 18'd10000, '0);
        send_command(sgsrw_pkg::KIND_GAIN, 18'd100000, '0);
        send_command(sgsrw_pkg::KIND_GAIN, 18'd124999, '0);
        send_command(sgsrw_pkg::KIND_GAIN, 18'd125000, '1);
        send_command(sgsrw_pkg::KIND_GAIN, 18'd125001, '0);
        send_command(sgsrw_pkg::KIND_GAIN, '1, '1);
        send_command(sgsrw_pkg::KIND_SHUTTER, '1, 24'd0);
        send_command(sgsrw_pkg::KIND_SHUTTER, '0, 24'd1124);
        send_command(sgsrw_pkg::KIND_SHUTTER, 18'h2AAAA, 24'd1125);
        send_command(sgsrw_pkg::KIND_SHUTTER, 18'h15555, 24'd1126);
        send_command(sgsrw_pkg::KIND_SHUTTER, '0, '1);
        send_command(sgsrw_pkg::KIND_SHUTTER, '0, 24'hA5A5A5);
    endtask

    // Stimulus: reset, directed commands, then random phases at various frame lengths.
    initial begin : stimulus
        logic [sgsrw_pkg::LINES_W-1:0] frame_value;
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_wdata     = '0;
        i_valid         = 1'b0;
        i_kind          = sgsrw_pkg::KIND_GAIN;
        i_gain_milli    = '0;
        i_shutter_lines = '0;
        sender_eager    = 1'b0;
        sink_eager      = 1'b0;
        frame_cfg       = sgsrw_pkg::FRAME_LINES_RST;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0:       frame_value = 24'd1;
                1:       frame_value = '1;
                2:       frame_value = '0;
                3:       frame_value = sgsrw_pkg::FRAME_LINES_RST;
                4:       frame_value = sgsrw_pkg::LINES_W'($urandom());
                default: frame_value = sgsrw_pkg::LINES_W'($urandom_range(1, 5000));
            endcase
            write_frame_lines(frame_value);
            sender_eager = (p % 3 == 1);
            sink_eager   = (p % 3 == 2);
            // Exposures at both ends of the field under each setting.
            send_command(sgsrw_pkg::KIND_SHUTTER, pick_gain(), '0);
            send_command(sgsrw_pkg::KIND_SHUTTER, pick_gain(), '1);
            for (int n = 0; n < PHASE_ITEMS - 2; n++) begin
                if (p == 3 && n == 20) begin
                    wait_drained();
                end
                send_random_command();
            end
        end

        // Let the last words out before the verdict.
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(posedge i_clk);
        if (err_count == 0 && writes_pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
